[hdl/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, constants and the microcode store for the four-level page
// table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   // Address geometry
   localparam int VA_W        = 48;
   localparam int PA_W        = 52;
   localparam int WORD_W      = 64;
   localparam int IDX_BITS    = 9;
   localparam int PAGE_SHIFT  = 12;
   localparam int ENTRY_SHIFT = 3;
   localparam int LEVELS      = 4;
   localparam int LVL_W       = 2;

   // Index positions inside the virtual address, top level first
   localparam int L0_SHIFT = 39;
   localparam int L1_SHIFT = 30;
   localparam int L2_SHIFT = 21;
   localparam int L3_SHIFT = 12;

   // Micro-operations driven into the datapath
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_ADDR,
      OP_SCAN,
      OP_NOP,
      OP_CHECK,
      OP_RESP
   } uop_type;

   // Branch conditions evaluated by the sequencer
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_XLATE,
      COND_SCAN_DONE,
      COND_WALK_STOP,
      COND_OUT_FREE
   } cond_type;

   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   // Microcode addresses
   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_ADDR  = 3'd1;
   localparam step_type STEP_SCAN  = 3'd2;
   localparam step_type STEP_DRAIN = 3'd3;
   localparam step_type STEP_CHECK = 3'd4;
   localparam step_type STEP_RESP  = 3'd5;

   // One control word: operation, branch condition, taken / not-taken targets
   typedef struct packed {
      uop_type  op;
      cond_type cond;
      step_type target_true;
      step_type target_false;
   } ucode_type;

   // Status flags fed back from the datapath to the sequencer
   typedef struct packed {
      logic xlate_go;
      logic scan_done;
      logic walk_stop;
      logic out_free;
   } status_type;

   // Control store
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type word;
      unique case (step)
         STEP_IDLE:  word = '{OP_IDLE,  COND_XLATE,     STEP_ADDR,  STEP_IDLE};
         STEP_ADDR:  word = '{OP_ADDR,  COND_ALWAYS,    STEP_SCAN,  STEP_SCAN};
         STEP_SCAN:  word = '{OP_SCAN,  COND_SCAN_DONE, STEP_DRAIN, STEP_SCAN};
         STEP_DRAIN: word = '{OP_NOP,   COND_ALWAYS,    STEP_CHECK, STEP_CHECK};
         STEP_CHECK: word = '{OP_CHECK, COND_WALK_STOP, STEP_RESP,  STEP_ADDR};
         STEP_RESP:  word = '{OP_RESP,  COND_OUT_FREE,  STEP_IDLE,  STEP_RESP};
         default:    word = '{OP_IDLE,  COND_ALWAYS,    STEP_IDLE,  STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

[hdl/ptw_sequencer.sv]
// ----------------------------------------------------------------------------
// ptw_sequencer
// Step counter over the microcode store; picks the next step from the
// branch condition of the current control word.
// ----------------------------------------------------------------------------
module ptw_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  ptw_pkg::status_type status,
   output ptw_pkg::uop_type    op
);
   import ptw_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   ucode_type word;
   logic      taken;

   // Fetch
   assign word = ucode_rom(step_ff);
   assign op   = word.op;

   // Branch evaluation
   always_comb begin
      unique case (word.cond)
         COND_ALWAYS:    taken = 1'b1;
         COND_XLATE:     taken = status.xlate_go;
         COND_SCAN_DONE: taken = status.scan_done;
         COND_WALK_STOP: taken = status.walk_stop;
         COND_OUT_FREE:  taken = status.out_free;
         default:        taken = 1'b1;
      endcase
      step_in = taken ? word.target_true : word.target_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Checks
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_SCAN && status.scan_done) |=> step_ff == STEP_DRAIN)
      else $error("scan did not exit to drain");

   a_xlate_start: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_IDLE && status.xlate_go) |=> step_ff == STEP_ADDR)
      else $error("translate request did not start a walk");

   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_RESP && !status.out_free) |=> step_ff == STEP_RESP)
      else $error("result dropped while output busy");

endmodule

[hdl/ptw_datapath.sv]
// ----------------------------------------------------------------------------
// ptw_datapath
// Entry store, sequential search unit, walk registers and result register,
// all steered by the micro-operation from the sequencer.
// ----------------------------------------------------------------------------
module ptw_datapath #(
   parameter int MEM_ENTRIES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ptw_pkg::uop_type                  op,
   output ptw_pkg::status_type               status,
   input  logic                              csr_write_enable,
   input  logic [ptw_pkg::WORD_W-1:0]        csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [ptw_pkg::WORD_W-1:0]        req_entry_address,
   input  logic [ptw_pkg::WORD_W-1:0]        req_entry_value,
   input  logic [ptw_pkg::WORD_W-1:0]        req_logical_address,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_fault,
   output logic [ptw_pkg::PA_W-1:0]          rsp_physical_address
);
   import ptw_pkg::*;

   localparam int CNT_W = $clog2(MEM_ENTRIES + 1);
   localparam int IDX_W = (MEM_ENTRIES > 1) ? $clog2(MEM_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MEM_ENTRIES);

   // Entry store: {address, value}
   logic [2*WORD_W-1:0] entry_mem_ff [MEM_ENTRIES];
   logic [2*WORD_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              hit_ff, hit_in;
   logic [WORD_W-1:0] ent_ff, ent_in;
   logic [WORD_W-1:0] root_ff, root_in;
   logic [VA_W-1:0]   la_ff, la_in;
   logic [WORD_W-1:0] base_ff, base_in;
   logic [WORD_W-1:0] ea_ff, ea_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic              fault_ff, fault_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_fault_ff, rsp_fault_in;
   logic [PA_W-1:0]   rsp_pa_ff, rsp_pa_in;

   logic             accept;
   logic             xlate_go;
   logic             do_load;
   logic             scan_rd;
   logic             match;
   logic             bad_entry;
   logic             out_free;
   logic             out_load;
   logic [IDX_BITS-1:0] idx;

   // Request side handshake
   assign req_stall = (op != OP_IDLE);
   assign accept    = (op == OP_IDLE) && req_valid;
   assign xlate_go  = accept && req_cmd;
   assign do_load   = accept && !req_cmd && (count_ff < CAPACITY);

   // Search read and compare
   assign scan_rd   = (op == OP_SCAN) && (scan_ff != count_ff);
   assign match     = rd_valid_ff && (rd_data_ff[2*WORD_W-1:WORD_W] == ea_ff);
   assign bad_entry = !hit_ff || !ent_ff[0];

   // Result register handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (op == OP_RESP) && out_free;

   assign status.xlate_go  = xlate_go;
   assign status.scan_done = (scan_ff == count_ff);
   assign status.walk_stop = bad_entry || (level_ff == LVL_W'(LEVELS - 1));
   assign status.out_free  = out_free;

   // Table index for the current level
   always_comb begin
      unique case (level_ff)
         2'd0:    idx = la_ff[L0_SHIFT +: IDX_BITS];
         2'd1:    idx = la_ff[L1_SHIFT +: IDX_BITS];
         2'd2:    idx = la_ff[L2_SHIFT +: IDX_BITS];
         default: idx = la_ff[L3_SHIFT +: IDX_BITS];
      endcase
   end

   // Next-state logic
   always_comb begin
      count_in     = do_load ? count_ff + CNT_W'(1) : count_ff;
      root_in      = csr_write_enable ? csr_write_data : root_ff;
      la_in        = xlate_go ? req_logical_address[VA_W-1:0] : la_ff;
      level_in     = level_ff;
      fault_in     = fault_ff;
      base_in      = base_ff;
      ea_in        = ea_ff;
      scan_in      = scan_rd ? scan_ff + CNT_W'(1) : scan_ff;
      rd_valid_in  = scan_rd;
      hit_in       = match ? 1'b1 : hit_ff;
      ent_in       = match ? rd_data_ff[WORD_W-1:0] : ent_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_pa_in    = rsp_pa_ff;

      if (xlate_go) begin
         level_in = '0;
         fault_in = 1'b0;
         base_in  = root_ff;
      end

      // Entry address: base + index * 8, modulo 2^64
      if (op == OP_ADDR) begin
         ea_in   = base_ff + {{(WORD_W-IDX_BITS-ENTRY_SHIFT){1'b0}}, idx,
                              {ENTRY_SHIFT{1'b0}}};
         scan_in = '0;
         hit_in  = 1'b0;
      end

      // Level check: fault or descend to the next table
      if (op == OP_CHECK) begin
         if (bad_entry) begin
            fault_in = 1'b1;
         end else begin
            base_in = {{(WORD_W-PA_W){1'b0}}, ent_ff[PA_W-1:PAGE_SHIFT],
                       {PAGE_SHIFT{1'b0}}};
         end
         level_in = level_ff + LVL_W'(1);
      end

      // Result register
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_fault_in = fault_ff;
         rsp_pa_in    = fault_ff ? '0
                                 : {base_ff[PA_W-1:PAGE_SHIFT], la_ff[PAGE_SHIFT-1:0]};
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Entry store write and registered read
   always_ff @(posedge clock) begin
      if (do_load) begin
         entry_mem_ff[count_ff[IDX_W-1:0]] <= {req_entry_address, req_entry_value};
      end
      if (scan_rd) begin
         rd_data_ff <= entry_mem_ff[scan_ff[IDX_W-1:0]];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         root_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         fault_ff     <= 1'b0;
         level_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         root_ff      <= root_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         fault_ff     <= fault_in;
         level_ff     <= level_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ent_ff       <= ent_in;
      la_ff        <= la_in;
      base_ff      <= base_in;
      ea_ff        <= ea_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_pa_ff    <= rsp_pa_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fault            = rsp_fault_ff;
   assign rsp_physical_address = rsp_pa_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAPACITY)
      else $error("entry count beyond capacity");

   a_store_frozen: assert property (@(posedge clock) disable iff (reset)
      (op != OP_IDLE) |=> $stable(count_ff))
      else $error("entry store changed during a walk");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= count_ff)
      else $error("search ran past the loaded entries");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fault_ff) |-> (rsp_pa_ff == '0))
      else $error("faulted result carries an address");

endmodule

[hdl/four_level_page_table_walk_unit.sv]
// ----------------------------------------------------------------------------
// four_level_page_table_walk_unit
// Four-level 48-bit page table walker over a sparse, loadable entry store.
//
// Usage:
//   req_* channel (valid/stall): req_cmd = 0 loads one {address, value} pair
//   into the entry store (no response; ignored once MEM_ENTRIES pairs are
//   held). req_cmd = 1 translates req_logical_address and yields one
//   response on the rsp_* channel: rsp_fault, or the 52-bit physical
//   address (zero on fault).
//   csr_write_enable/csr_write_data set the root table address; write only
//   while no translation is in flight.
//   A load is taken while the walker is idle. A translation visits each
//   level in turn (entry address, search, drain, check) up to a fault or
//   the last level, then loads the result. The search over the store, one
//   entry read per cycle from its single read port, sets how long a level takes.
//   Reset clears the store count, the root register and all control; store
//   contents are not cleared. A stalled response is held in the output
//   register; loads are still taken meanwhile, and a following translation
//   waits at its last step until the register frees up.
// ----------------------------------------------------------------------------
module four_level_page_table_walk_unit #(
   parameter int MEM_ENTRIES = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [ptw_pkg::WORD_W-1:0] csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cmd,
   input  logic [ptw_pkg::WORD_W-1:0] req_entry_address,
   input  logic [ptw_pkg::WORD_W-1:0] req_entry_value,
   input  logic [ptw_pkg::WORD_W-1:0] req_logical_address,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_fault,
   output logic [ptw_pkg::PA_W-1:0]   rsp_physical_address
);
   import ptw_pkg::*;

   uop_type    op;
   status_type status;

   // Microcode sequencer
   ptw_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   // Datapath with entry store and search unit
   ptw_datapath #(
      .MEM_ENTRIES (MEM_ENTRIES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .op                   (op),
      .status               (status),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_entry_address    (req_entry_address),
      .req_entry_value      (req_entry_value),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_fault            (rsp_fault),
      .rsp_physical_address (rsp_physical_address)
   );

endmodule

[dv/four_level_page_table_walk_unit_test.sv]
// ----------------------------------------------------------------------------
// four_level_page_table_walk_unit_test
// Self-checking bench for the four-level page table walker. Requests load
// page table entries into the block's entry store or translate addresses.
// A scoreboard keeps its own copy of the store and the root register, walks
// each accepted translation itself and compares every response in order.
// The run goes through directed walks, random path building with random
// flow control gaps on both sides, a long response back-pressure hold and a
// full entry store.
// ----------------------------------------------------------------------------
module four_level_page_table_walk_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ptw_pkg::*;

   // Smaller store than the default keeps walks short and lets it fill up
   localparam int unsigned STORE_DEPTH  = 64;
   localparam int unsigned STORE_GUARD  = 8;
   localparam int unsigned WALK_MAX     = 4 * (STORE_DEPTH + 4) + 2;
   localparam int unsigned HOLD_CYCLES  = 2 * WALK_MAX + 200;
   localparam int unsigned SETTLE       = 8;
   localparam int unsigned LIMIT_CYCLES = 1000000;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_XLATE = 1'b1
   } walk_cmd_type;

   typedef struct packed {
      logic            fault;
      logic [PA_W-1:0] phys;
   } walk_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: entry store copy, root register, expected responses
   // -------------------------------------------------------------------------
   class walk_scoreboard;
      logic [WORD_W-1:0] entry_addr [STORE_DEPTH];
      logic [WORD_W-1:0] entry_val  [STORE_DEPTH];
      int unsigned       entry_count;
      logic [WORD_W-1:0] root;
      walk_result_type   expected_q [$];
      int unsigned       errors, xlates, faults, loads_kept, loads_dropped;

      function new();
         entry_count   = 0;
         root          = '0;
         errors        = 0;
         xlates        = 0;
         faults        = 0;
         loads_kept    = 0;
         loads_dropped = 0;
      endfunction

      function int unsigned room_left();
         return STORE_DEPTH - entry_count;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // last matching pair wins
      function bit find_entry(input logic [WORD_W-1:0] addr,
                              output logic [WORD_W-1:0] val);
         bit hit;
         hit = 1'b0;
         val = '0;
         for (int k = 0; k < entry_count; k++) begin
            if (entry_addr[k] == addr) begin
               val = entry_val[k];
               hit = 1'b1;
            end
         end
         return hit;
      endfunction

      // Walks the levels; returns the level that faulted, or LEVELS on a hit.
      // ea is the entry address of the last level looked at.
      function int trace(input logic [WORD_W-1:0] la, output logic [WORD_W-1:0] ea,
                         output logic [WORD_W-1:0] tbl);
         logic [WORD_W-1:0]   ent;
         logic [IDX_BITS-1:0] idx;
         int                  lv;
         tbl = root;
         ea  = '0;
         for (lv = 0; lv < LEVELS; lv++) begin
            idx = la[PAGE_SHIFT + IDX_BITS * (LEVELS - 1 - lv) +: IDX_BITS];
            ea  = tbl + (WORD_W'(idx) << ENTRY_SHIFT);
            if (!find_entry(ea, ent) || !ent[0])
               return lv;
            tbl = '0;
            tbl[PA_W-1:PAGE_SHIFT] = ent[PA_W-1:PAGE_SHIFT];
         end
         return lv;
      endfunction

      function walk_result_type translate(input logic [WORD_W-1:0] la);
         walk_result_type   r;
         logic [WORD_W-1:0] ea, tbl;
         r = '0;
         if (trace(la, ea, tbl) == LEVELS)
            r.phys = tbl[PA_W-1:0] + PA_W'(la[PAGE_SHIFT-1:0]);
         else
            r.fault = 1'b1;
         return r;
      endfunction

      function void note_request(input walk_cmd_type cmd, input logic [WORD_W-1:0] ea,
                                 input logic [WORD_W-1:0] ev,
                                 input logic [WORD_W-1:0] la);
         walk_result_type r;
         if (cmd == CMD_LOAD) begin
            // loads past capacity are dropped by the block
            if (entry_count < STORE_DEPTH) begin
               entry_addr[entry_count] = ea;
               entry_val[entry_count]  = ev;
               entry_count++;
               loads_kept++;
            end else begin
               loads_dropped++;
            end
         end else begin
            r = translate(la);
            expected_q.push_back(r);
            xlates++;
            if (r.fault)
               faults++;
         end
      endfunction

      function void check_response(input logic fault, input logic [PA_W-1:0] phys);
         walk_result_type want;
         if (expected_q.size() == 0) begin
            $error("response with no translation outstanding: fault=%0d physical_address=%h",
                   fault, phys);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (fault !== want.fault) begin
            $error("fault: expected %0d, got %0d", want.fault, fault);
            errors++;
         end
         if (phys !== want.phys) begin
            $error("physical_address: expected %h, got %h", want.phys, phys);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and DUT
   // -------------------------------------------------------------------------
   logic              clock;
   logic              reset               = 1'b1;
   logic              csr_write_enable    = 1'b0;
   logic [WORD_W-1:0] csr_write_data      = '0;
   logic              req_valid           = 1'b0;
   logic              req_stall;
   logic              req_cmd             = 1'b0;
   logic [WORD_W-1:0] req_entry_address   = '0;
   logic [WORD_W-1:0] req_entry_value     = '0;
   logic [WORD_W-1:0] req_logical_address = '0;
   logic              rsp_valid;
   logic              rsp_stall           = 1'b0;
   logic              rsp_fault;
   logic [PA_W-1:0]   rsp_physical_address;

   walk_scoreboard sb = new();

   int unsigned       send_idle_pct = 34;
   int unsigned       rcv_idle_pct  = 79;
   bit                hold_pending  = 1'b0;
   int unsigned       requests_sent = 0;
   int unsigned       cycle_count   = 0;
   logic [WORD_W-1:0] last_la       = '0;

   four_level_page_table_walk_unit #(
      .MEM_ENTRIES(STORE_DEPTH)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_entry_address    (req_entry_address),
      .req_entry_value      (req_entry_value),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_fault            (rsp_fault),
      .rsp_physical_address (rsp_physical_address)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, sb.pending());
         $display("** four_level_page_table_walk_unit: FAILED **");
         $finish;
      end
   end

   // Response side: random stalls, or a long hold when asked for
   initial begin : rsp_side
      int unsigned n;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_fault, rsp_physical_address);
   end

   // -------------------------------------------------------------------------
   // Request driving
   // -------------------------------------------------------------------------
   function automatic logic [WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_request(input walk_cmd_type cmd, input logic [WORD_W-1:0] ea,
                               input logic [WORD_W-1:0] ev, input logic [WORD_W-1:0] la);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_cmd             <= cmd;
      req_entry_address   <= ea;
      req_entry_value     <= ev;
      req_logical_address <= la;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, ea, ev, la);
      requests_sent++;
   endtask

   // unused fields carry random junk
   task automatic send_load(input logic [WORD_W-1:0] ea, input logic [WORD_W-1:0] ev);
      send_request(CMD_LOAD, ea, ev, rand64());
   endtask

   task automatic send_xlate(input logic [WORD_W-1:0] la);
      send_request(CMD_XLATE, rand64(), rand64(), la);
   endtask

   // Drop valid and wait until every response is back and the block is quiet
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_root(input logic [WORD_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.root = value;
   endtask

   // One random sequence: mostly a translation that shares the upper levels
   // of the previous one, with the missing entries loaded first
   task automatic walk_sequence();
      logic [WORD_W-1:0] la, ea, tbl;
      logic [VA_W-1:0]   keep_mask;
      int unsigned       pick, keep;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         // noise: stray load or a translation of a random address
         if ($urandom_range(0, 1) && sb.room_left() > STORE_GUARD)
            send_load(rand64(), rand64());
         else
            send_xlate(rand64());
         return;
      end
      keep = (pick < 30) ? 4 : (pick < 60) ? 3 : (pick < 78) ? 2 : (pick < 90) ? 1 : 0;
      keep_mask = {VA_W{1'b1}} << (VA_W - IDX_BITS * keep);
      la = rand64();
      la[VA_W-1:0] = (la[VA_W-1:0] & ~keep_mask) | (last_la[VA_W-1:0] & keep_mask);
      while (sb.trace(la, ea, tbl) < LEVELS && sb.room_left() > STORE_GUARD) begin
         if ($urandom_range(0, 99) < 6) begin
            // entry without the present bit
            send_load(ea, rand64() & ~64'h1);
            break;
         end
         send_load(ea, rand64() | 64'h1);
      end
      send_xlate(la);
      last_la = la;
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned start;
      start = requests_sent;
      while (requests_sent - start < count)
         walk_sequence();
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [WORD_W-1:0] ea, tbl;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed walks, root still at its reset value of zero
      send_xlate(64'hFFFF_FFFF_FFFF_FFFF);                 // empty store
      send_load(64'h0, 64'h0000_0000_0001_0FFE);           // present bit clear
      send_xlate(64'h0);
      send_load(64'h0, 64'hFFF0_0000_0001_0001);           // same address, now present
      send_load(64'h0000_0000_0001_0000, 64'h0000_0000_0002_0001);
      send_load(64'h0000_0000_0002_0000, 64'h8000_0000_0003_0003);
      send_load(64'h0000_0000_0003_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_xlate(64'hFFFF_0000_0000_0FFF);                 // upper bits ignored, max frame
      send_xlate(64'h0000_0000_0000_1000);                 // miss at the last level
      // all indices at 511
      send_load(64'h0000_0000_0000_0FF8, 64'h0008_0000_0000_0001);
      send_load(64'h0008_0000_0000_0FF8, 64'h000F_FFFF_FFFF_E001);
      send_load(64'h000F_FFFF_FFFF_EFF8, 64'h0000_0000_0004_0001);
      send_load(64'h0000_0000_0004_0FF8, 64'h0001_2345_6789_A001);
      send_xlate(64'h0000_FFFF_FFFF_FFFF);
      // root just below the top: the level-0 entry address wraps to zero
      wait_drained();
      write_root(64'hFFFF_FFFF_FFFF_FFF8);
      send_xlate(64'h0000_0080_0000_0123);
      send_xlate(64'h0);
      last_la = 64'h0000_0080_0000_0123;
      run_random(30);

      // Sender busy, receiver mostly free
      wait_drained();
      send_idle_pct = 79;
      rcv_idle_pct  = 34;
      write_root(rand64());
      run_random(45);

      // No gaps; long response hold while requests keep coming
      wait_drained();
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      write_root(64'hFFFF_FFFF_FFFF_FFFF);
      hold_pending = 1'b1;
      send_xlate(rand64());
      send_load(rand64(), rand64());
      send_xlate(last_la);
      send_load(rand64(), rand64());
      send_xlate(rand64());
      send_xlate(last_la);
      wait_drained();
      run_random(40);

      // Fill the store, then loads must be dropped
      while (sb.room_left() > 0)
         send_load(rand64(), rand64());
      void'(sb.trace(last_la, ea, tbl));
      send_load(ea, 64'h0);                                // would break the walk if kept
      send_load(rand64(), rand64() | 64'h1);
      send_xlate(last_la);
      send_xlate(rand64());

      wait_drained();
      repeat (WALK_MAX) @(posedge clock);

      $display("Covered %0d translations (%0d faulted) and %0d loads, %0d dropped on a full store.",
               sb.xlates, sb.faults, sb.loads_kept + sb.loads_dropped, sb.loads_dropped);
      $display("Roots at zero, all ones, near the wrap and random; gaps on each side and none.");
      if (sb.errors == 0)
         $display("** four_level_page_table_walk_unit: PASSED **");
      else
         $display("** four_level_page_table_walk_unit: FAILED **");
      $finish;
   end

endmodule

[four_level_page_table_walk_unit.f]
hdl/ptw_pkg.sv
hdl/ptw_sequencer.sv
hdl/ptw_datapath.sv
hdl/four_level_page_table_walk_unit.sv
dv/four_level_page_table_walk_unit_test.sv
